### sv/pn_pkg.sv
// ----------------------------------------------------------------------------
// pn_pkg
// Shared types, codes and helpers for the path normalizer.
// ----------------------------------------------------------------------------
package pn_pkg;

   localparam int unsigned ByteW = 8;

   // result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BADCHAR = 2'd1;
   localparam logic [1:0] ST_TOOLONG = 2'd2;

   // request function codes
   localparam logic FN_PATH = 1'b0;
   localparam logic FN_READ = 1'b1;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_RDATA, S_START, S_COPY, S_CPEND,
      S_BYTE, S_UP, S_UPW, S_WR, S_TERM, S_EMIT
   } state_type;

   // letters, digits, dash, dot, underscore
   function automatic logic char_ok(input logic [7:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || c == CH_DASH || c == CH_DOT ||
             c == CH_UNDER;
   endfunction

endpackage

### sv/path_normalizer.sv
// ----------------------------------------------------------------------------
// path_normalizer
// Lexical path normalization against a kept current directory.
// ----------------------------------------------------------------------------
// One request at a time. A read passes through S_RDATA, then S_EMIT for the
// output hand-off. A path byte that opens a component goes to S_WR, which
// writes the separator, the held dots and the byte one per cycle; the
// terminator passes through S_TERM and S_EMIT for the output hand-off. A
// relative path first copies the current directory through the single read
// port of the buffer. A ".." component walks back byte by byte in the scratch
// buffer through S_UP and S_UPW until it stops at the root or a separator.
// Commit is a swap of the two directory buffers. After reset S_INIT writes
// the root slash before the first request is taken.
// ----------------------------------------------------------------------------
module path_normalizer #(
   parameter int unsigned MAX_LEN = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [7:0] req_character,
   input  logic [7:0] req_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [8:0] rsp_dir_length,
   output logic [7:0] rsp_read_byte
);

   localparam int unsigned AW = $clog2(MAX_LEN);
   localparam int unsigned LW = $clog2(MAX_LEN + 1);
   localparam int unsigned CW = (LW > 8) ? LW : 8;
   localparam int unsigned SW = LW + 2;

   pn_pkg::state_type state_ff, state_in;

   logic          sel_ff, sel_in;
   logic [LW-1:0] cur_len_ff, cur_len_in;
   logic [LW-1:0] slen_ff, slen_in;
   logic [LW-1:0] cstart_ff, cstart_in;
   logic [LW-1:0] cnt_ff, cnt_in;
   logic          in_path_ff, in_path_in;
   logic [1:0]    err_ff, err_in;
   logic [1:0]    dots_ff, dots_in;
   logic          slash_ff, slash_in;
   logic          cp_v_ff, cp_v_in;
   logic [AW-1:0] cp_addr_ff, cp_addr_in;
   logic          func_ff;
   logic [7:0]    chr_ff;
   logic [7:0]    idx_ff;
   logic [1:0]    res_st_ff, res_st_in;
   logic [LW-1:0] res_len_ff, res_len_in;
   logic [7:0]    res_byte_ff, res_byte_in;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_st_ff;
   logic [8:0]    rsp_len_ff;
   logic [7:0]    rsp_byte_ff;

   // memory controls
   logic          scr_we;
   logic [AW-1:0] scr_waddr, scr_raddr, cur_raddr;
   logic [7:0]    scr_wdata, cur_rdata, scr_rdata;
   logic          a_we, b_we;
   logic [AW-1:0] a_waddr, a_raddr, b_raddr;
   logic [7:0]    a_wdata, rd_a, rd_b;

   logic accept, emit_go, up_hit, over;

   assign accept  = req_valid && req_ready;
   assign emit_go = !rsp_valid_ff || rsp_ready;
   assign up_hit  = (slen_ff == cstart_ff) && (dots_ff == 2'd2);
   assign over    = (SW'(slen_ff) + SW'(slen_ff > LW'(1)) + SW'(dots_ff) + SW'(1))
                    > SW'(MAX_LEN);

   // buffer steering: sel_ff names the buffer holding the committed directory
   assign a_we      = (state_ff == pn_pkg::S_INIT) || (scr_we && sel_ff);
   assign b_we      = scr_we && !sel_ff;
   assign a_waddr   = (state_ff == pn_pkg::S_INIT) ? '0 : scr_waddr;
   assign a_wdata   = (state_ff == pn_pkg::S_INIT) ? pn_pkg::CH_SLASH : scr_wdata;
   assign a_raddr   = sel_ff ? scr_raddr : cur_raddr;
   assign b_raddr   = sel_ff ? cur_raddr : scr_raddr;
   assign cur_rdata = sel_ff ? rd_b : rd_a;
   assign scr_rdata = sel_ff ? rd_a : rd_b;

   pn_buf #(.DEPTH(MAX_LEN)) u_buf_a (
      .clock(clock), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
      .raddr(a_raddr), .rdata(rd_a)
   );

   pn_buf #(.DEPTH(MAX_LEN)) u_buf_b (
      .clock(clock), .we(b_we), .waddr(scr_waddr), .wdata(scr_wdata),
      .raddr(b_raddr), .rdata(rd_b)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pn_pkg::S_INIT:  state_in = pn_pkg::S_IDLE;
         pn_pkg::S_IDLE: begin
            if (accept) begin
               if (req_func == pn_pkg::FN_READ) state_in = pn_pkg::S_RDATA;
               else if (in_path_ff)             state_in = pn_pkg::S_BYTE;
               else                             state_in = pn_pkg::S_START;
            end
         end
         pn_pkg::S_RDATA: state_in = pn_pkg::S_EMIT;
         pn_pkg::S_START: begin
            if (chr_ff == pn_pkg::CH_SLASH || chr_ff == pn_pkg::CH_NUL)
               state_in = pn_pkg::S_BYTE;
            else
               state_in = pn_pkg::S_COPY;
         end
         pn_pkg::S_COPY: begin
            if (cnt_ff + LW'(1) == cur_len_ff) state_in = pn_pkg::S_CPEND;
         end
         pn_pkg::S_CPEND: state_in = pn_pkg::S_BYTE;
         pn_pkg::S_BYTE: begin
            priority if (chr_ff == pn_pkg::CH_NUL)
               state_in = (err_ff == pn_pkg::ST_OK && up_hit) ? pn_pkg::S_UP
                                                              : pn_pkg::S_TERM;
            else if (err_ff != pn_pkg::ST_OK) state_in = pn_pkg::S_IDLE;
            else if (chr_ff == pn_pkg::CH_SLASH)
               state_in = up_hit ? pn_pkg::S_UP : pn_pkg::S_IDLE;
            else if (!pn_pkg::char_ok(chr_ff)) state_in = pn_pkg::S_IDLE;
            else if (slen_ff == cstart_ff && !(chr_ff == pn_pkg::CH_DOT &&
                     dots_ff < 2'd2) && !over)
               state_in = pn_pkg::S_WR;
            else state_in = pn_pkg::S_IDLE;
         end
         pn_pkg::S_UP: begin
            if (slen_ff > LW'(1)) state_in = pn_pkg::S_UPW;
            else state_in = (chr_ff == pn_pkg::CH_NUL) ? pn_pkg::S_TERM : pn_pkg::S_IDLE;
         end
         pn_pkg::S_UPW: begin
            if (scr_rdata != pn_pkg::CH_SLASH) state_in = pn_pkg::S_UP;
            else state_in = (chr_ff == pn_pkg::CH_NUL) ? pn_pkg::S_TERM : pn_pkg::S_IDLE;
         end
         pn_pkg::S_WR: begin
            if (!slash_ff && dots_ff == 2'd0) state_in = pn_pkg::S_IDLE;
         end
         pn_pkg::S_TERM: state_in = pn_pkg::S_EMIT;
         pn_pkg::S_EMIT: if (emit_go) state_in = pn_pkg::S_IDLE;
         default: state_in = pn_pkg::S_IDLE;
      endcase
   end

   // outputs and datapath next values
   always_comb begin
      req_ready   = (state_ff == pn_pkg::S_IDLE);
      cur_raddr   = AW'(req_index);
      scr_raddr   = AW'(slen_ff - LW'(1));
      scr_we      = 1'b0;
      scr_waddr   = slen_ff[AW-1:0];
      scr_wdata   = chr_ff;
      sel_in      = sel_ff;
      cur_len_in  = cur_len_ff;
      slen_in     = slen_ff;
      cstart_in   = cstart_ff;
      cnt_in      = cnt_ff;
      in_path_in  = in_path_ff;
      err_in      = err_ff;
      dots_in     = dots_ff;
      slash_in    = slash_ff;
      cp_v_in     = 1'b0;
      cp_addr_in  = cp_addr_ff;
      res_st_in   = res_st_ff;
      res_len_in  = res_len_ff;
      res_byte_in = res_byte_ff;
      unique case (state_ff)
         pn_pkg::S_RDATA: begin
            res_st_in   = pn_pkg::ST_OK;
            res_len_in  = cur_len_ff;
            res_byte_in = (CW'(idx_ff) < CW'(cur_len_ff)) ? cur_rdata : 8'd0;
         end
         pn_pkg::S_START: begin
            in_path_in = 1'b1;
            err_in     = pn_pkg::ST_OK;
            dots_in    = 2'd0;
            cnt_in     = '0;
            if (chr_ff == pn_pkg::CH_SLASH || chr_ff == pn_pkg::CH_NUL) begin
               scr_we    = 1'b1;
               scr_waddr = '0;
               scr_wdata = pn_pkg::CH_SLASH;
               slen_in   = LW'(1);
               cstart_in = LW'(1);
            end else begin
               slen_in   = cur_len_ff;
               cstart_in = cur_len_ff;
            end
         end
         pn_pkg::S_COPY: begin
            cur_raddr  = cnt_ff[AW-1:0];
            cp_v_in    = 1'b1;
            cp_addr_in = cnt_ff[AW-1:0];
            cnt_in     = cnt_ff + LW'(1);
            scr_we     = cp_v_ff;
            scr_waddr  = cp_addr_ff;
            scr_wdata  = cur_rdata;
         end
         pn_pkg::S_CPEND: begin
            scr_we    = cp_v_ff;
            scr_waddr = cp_addr_ff;
            scr_wdata = cur_rdata;
         end
         pn_pkg::S_BYTE: begin
            priority if (chr_ff == pn_pkg::CH_NUL) begin
               // handled in S_UP / S_TERM
            end else if (err_ff != pn_pkg::ST_OK) begin
               // first error wins
            end else if (chr_ff == pn_pkg::CH_SLASH) begin
               if (!up_hit) begin
                  dots_in   = 2'd0;
                  cstart_in = slen_ff;
               end
            end else if (!pn_pkg::char_ok(chr_ff)) begin
               err_in = pn_pkg::ST_BADCHAR;
            end else if (slen_ff == cstart_ff) begin
               priority if (chr_ff == pn_pkg::CH_DOT && dots_ff < 2'd2)
                  dots_in = dots_ff + 2'd1;
               else if (over) err_in = pn_pkg::ST_TOOLONG;
               else slash_in = (slen_ff > LW'(1));
            end else if (slen_ff >= LW'(MAX_LEN)) begin
               err_in = pn_pkg::ST_TOOLONG;
            end else begin
               scr_we  = 1'b1;
               slen_in = slen_ff + LW'(1);
            end
         end
         pn_pkg::S_UP: begin
            if (slen_ff <= LW'(1)) begin
               dots_in   = 2'd0;
               cstart_in = slen_ff;
            end
         end
         pn_pkg::S_UPW: begin
            slen_in = slen_ff - LW'(1);
            if (scr_rdata == pn_pkg::CH_SLASH) begin
               dots_in   = 2'd0;
               cstart_in = slen_ff - LW'(1);
            end
         end
         pn_pkg::S_WR: begin
            // separator, held dots, then the byte itself
            scr_we  = 1'b1;
            slen_in = slen_ff + LW'(1);
            priority if (slash_ff) begin
               scr_wdata = pn_pkg::CH_SLASH;
               slash_in  = 1'b0;
            end else if (dots_ff != 2'd0) begin
               scr_wdata = pn_pkg::CH_DOT;
               dots_in   = dots_ff - 2'd1;
            end else begin
               scr_wdata = chr_ff;
            end
         end
         pn_pkg::S_TERM: begin
            if (err_ff == pn_pkg::ST_OK) begin
               sel_in     = !sel_ff;
               cur_len_in = slen_ff;
               res_len_in = slen_ff;
            end else begin
               res_len_in = cur_len_ff;
            end
            res_st_in   = err_ff;
            res_byte_in = 8'd0;
            in_path_in  = 1'b0;
            err_in      = pn_pkg::ST_OK;
            dots_in     = 2'd0;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pn_pkg::S_INIT;
         sel_ff       <= 1'b0;
         cur_len_ff   <= LW'(1);
         slen_ff      <= '0;
         cstart_ff    <= '0;
         in_path_ff   <= 1'b0;
         err_ff       <= pn_pkg::ST_OK;
         dots_ff      <= 2'd0;
         slash_ff     <= 1'b0;
         cp_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sel_ff     <= sel_in;
         cur_len_ff <= cur_len_in;
         slen_ff    <= slen_in;
         cstart_ff  <= cstart_in;
         in_path_ff <= in_path_in;
         err_ff     <= err_in;
         dots_ff    <= dots_in;
         slash_ff   <= slash_in;
         cp_v_ff    <= cp_v_in;
         if (state_ff == pn_pkg::S_EMIT && emit_go) rsp_valid_ff <= 1'b1;
         else if (rsp_ready)                        rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      cp_addr_ff  <= cp_addr_in;
      res_st_ff   <= res_st_in;
      res_len_ff  <= res_len_in;
      res_byte_ff <= res_byte_in;
      if (accept) begin
         func_ff <= req_func;
         chr_ff  <= req_character;
         idx_ff  <= req_index;
      end
      if (state_ff == pn_pkg::S_EMIT && emit_go) begin
         rsp_st_ff   <= res_st_ff;
         rsp_len_ff  <= 9'(res_len_ff);
         rsp_byte_ff <= (func_ff == pn_pkg::FN_READ) ? res_byte_ff : 8'd0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_st_ff;
   assign rsp_dir_length = rsp_len_ff;
   assign rsp_read_byte  = rsp_byte_ff;

endmodule

### sv/pn_buf.sv
// ----------------------------------------------------------------------------
// pn_buf
// Directory byte buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pn_buf #(
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [pn_pkg::ByteW-1:0] wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [pn_pkg::ByteW-1:0] rdata
);

   logic [pn_pkg::ByteW-1:0] mem [DEPTH];
   logic [pn_pkg::ByteW-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/pn_checker.sv
// ----------------------------------------------------------------------------
// pn_checker
// Port-level checks on the path normalizer result channel.
// ----------------------------------------------------------------------------
module pn_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [8:0] rsp_dir_length,
   input logic [7:0] rsp_read_byte
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_dir_length) && $stable(rsp_read_byte))
      else $error("stalled response changed");

   // status is a defined code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == pn_pkg::ST_OK || rsp_status == pn_pkg::ST_BADCHAR ||
      rsp_status == pn_pkg::ST_TOOLONG)
      else $error("bad status code");

   // rejected paths carry no directory byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != pn_pkg::ST_OK |-> rsp_read_byte == 8'd0)
      else $error("byte on error response");

   // directory always holds at least the root
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dir_length != 9'd0)
      else $error("empty directory reported");

endmodule

bind path_normalizer pn_checker u_pn_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_status(rsp_status), .rsp_dir_length(rsp_dir_length),
   .rsp_read_byte(rsp_read_byte)
);

### verif/path_normalizer_test.sv
// ----------------------------------------------------------------------------
// path_normalizer_test
// Self-checking bench for the path normalizer. A table of directed requests
// (reset state, read extremes, bad bytes, dot components) is followed by
// random paths built from names, "." and ".." components, with some long
// components, bad bytes, noise and reads mixed in. A behavioral copy of the
// directory logic predicts each response; responses are checked in order.
// ----------------------------------------------------------------------------
module path_normalizer_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DirMax = 256;
   localparam int NumItems = 1350;

   typedef struct packed {
      logic [1:0] status;
      logic [8:0] dir_length;
      logic [7:0] read_byte;
   } response_type;

   typedef struct {
      logic         func;
      logic [7:0]   ch;
      logic [7:0]   idx;
      bit           typed;
      response_type rsp;
   } dir_row_type;

   logic       clock, reset;
   logic       req_valid, req_ready, req_func;
   logic [7:0] req_character, req_index;
   logic       rsp_valid, rsp_ready;
   logic [1:0] rsp_status;
   logic [8:0] rsp_dir_length;
   logic [7:0] rsp_read_byte;

   path_normalizer #(.MAX_LEN(DirMax)) u_dut (.*);

   // model of the directory state
   logic [7:0] cur_dir [DirMax];
   logic [7:0] scr_dir [DirMax];
   int         cur_len, scr_len, comp_start, pend_dots;
   bit         in_path;
   logic [1:0] path_err;

   response_type pending_rsp [$];
   int           failures = 0;
   int           sent = 0;
   bit           quiet = 0;

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // overall time limit
   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   function automatic bit is_name_char(logic [7:0] c);
      return (c >= pn_pkg::CH_ZERO && c <= pn_pkg::CH_NINE) || (c >= "A" && c <= "Z") ||
             (c >= "a" && c <= "z") || c == pn_pkg::CH_DASH || c == pn_pkg::CH_DOT ||
             c == pn_pkg::CH_UNDER;
   endfunction

   function automatic void climb_up();
      while (scr_len > 1 && scr_dir[scr_len-1] != pn_pkg::CH_SLASH) scr_len--;
      if (scr_len > 1) scr_len--;
   endfunction

   function automatic void close_component();
      if (scr_len == comp_start && pend_dots == 2) climb_up();
      pend_dots = 0;
      comp_start = scr_len;
   endfunction

   function automatic void append_char(logic [7:0] c);
      int need;
      if (scr_len == comp_start) begin
         if (c == pn_pkg::CH_DOT && pend_dots < 2) begin
            pend_dots++;
            return;
         end
         need = (scr_len > 1 ? 1 : 0) + pend_dots + 1;
         if (scr_len + need > DirMax) begin
            path_err = pn_pkg::ST_TOOLONG;
            return;
         end
         if (scr_len > 1) scr_dir[scr_len++] = pn_pkg::CH_SLASH;
         for (int k = 0; k < pend_dots; k++) scr_dir[scr_len++] = pn_pkg::CH_DOT;
         scr_dir[scr_len++] = c;
         pend_dots = 0;
      end else begin
         if (scr_len >= DirMax) begin
            path_err = pn_pkg::ST_TOOLONG;
            return;
         end
         scr_dir[scr_len++] = c;
      end
   endfunction

   // advance the model by one request; returns 1 with the response if any
   function automatic bit normalize_step(logic func, logic [7:0] c, logic [7:0] idx,
                                         output response_type r);
      r = '0;
      if (func == pn_pkg::FN_READ) begin
         r.dir_length = cur_len[8:0];
         r.read_byte = (idx < cur_len) ? cur_dir[idx] : 8'h00;
         return 1;
      end
      if (!in_path) begin
         in_path = 1;
         path_err = pn_pkg::ST_OK;
         pend_dots = 0;
         if (c == pn_pkg::CH_SLASH || c == pn_pkg::CH_NUL) begin
            scr_dir[0] = pn_pkg::CH_SLASH;
            scr_len = 1;
         end else begin
            for (int k = 0; k < cur_len; k++) scr_dir[k] = cur_dir[k];
            scr_len = cur_len;
         end
         comp_start = scr_len;
      end
      if (c == pn_pkg::CH_NUL) begin
         if (path_err == pn_pkg::ST_OK) begin
            close_component();
            for (int k = 0; k < scr_len; k++) cur_dir[k] = scr_dir[k];
            cur_len = scr_len;
         end
         r.status = path_err;
         r.dir_length = cur_len[8:0];
         in_path = 0;
         path_err = pn_pkg::ST_OK;
         pend_dots = 0;
         return 1;
      end
      if (path_err != pn_pkg::ST_OK) return 0;
      if (c == pn_pkg::CH_SLASH) close_component();
      else if (!is_name_char(c)) path_err = pn_pkg::ST_BADCHAR;
      else append_char(c);
      return 0;
   endfunction

   // drive one request and wait for it to be taken
   task automatic send_request(logic func, logic [7:0] c, logic [7:0] idx,
                               bit typed = 0, response_type typed_rsp = '0);
      response_type r;
      if (!quiet && $urandom_range(99) < 11) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1;
      req_func <= func;
      req_character <= c;
      req_index <= idx;
      do @(posedge clock); while (!req_ready);
      sent++;
      if (normalize_step(func, c, idx, r)) pending_rsp.push_back(typed ? typed_rsp : r);
   endtask

   function automatic logic [7:0] pick_name_char();
      logic [7:0] c;
      do c = 8'($urandom_range(8'h2D, 8'h7A)); while (!is_name_char(c));
      return c;
   endfunction

   function automatic logic [7:0] pick_bad_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (is_name_char(c) || c == pn_pkg::CH_SLASH);
      return c;
   endfunction

   // build one random path, terminator included
   task automatic random_path();
      logic [7:0] bytes [$];
      int ncomp, kind, len;
      bytes = {};
      if ($urandom_range(99) < 40) bytes.push_back(pn_pkg::CH_SLASH);
      ncomp = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 5);
      for (int i = 0; i < ncomp; i++) begin
         kind = $urandom_range(99);
         if (i > 0) bytes.push_back(pn_pkg::CH_SLASH);
         if (kind < 15) bytes.push_back(pn_pkg::CH_DOT);
         else if (kind < 32) begin
            bytes.push_back(pn_pkg::CH_DOT);
            bytes.push_back(pn_pkg::CH_DOT);
         end else if (kind < 36) begin
            // empty component from a doubled slash
         end else begin
            len = ($urandom_range(99) < 3) ? $urandom_range(200, 270) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++) bytes.push_back(pick_name_char());
         end
      end
      // a bad byte somewhere, or random noise
      if (bytes.size() > 0 && $urandom_range(99) < 5)
         bytes[$urandom_range(bytes.size()-1)] = pick_bad_char();
      if (bytes.size() > 0 && $urandom_range(99) < 3)
         bytes[$urandom_range(bytes.size()-1)] = 8'($urandom_range(1, 255));
      bytes.push_back(pn_pkg::CH_NUL);
      foreach (bytes[i]) begin
         if ($urandom_range(99) < 8)
            send_request(pn_pkg::FN_READ, 8'($urandom),
                         ($urandom_range(1) ? 8'($urandom_range(cur_len))
                                            : 8'($urandom_range(255))));
         send_request(pn_pkg::FN_PATH, bytes[i], 8'($urandom));
      end
   endtask

   // response side: ready pattern
   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= quiet || ($urandom_range(99) >= 11);
   end

   // response check
   always @(posedge clock) begin
      response_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response status=%0d len=%0d byte=%h", $time,
                     rsp_status, rsp_dir_length, rsp_read_byte);
            failures++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_status !== exp_rsp.status || rsp_dir_length !== exp_rsp.dir_length ||
                rsp_read_byte !== exp_rsp.read_byte) begin
               $display("%0t: mismatch expected status=%0d len=%0d byte=%h, got %0d %0d %h",
                        $time, exp_rsp.status, exp_rsp.dir_length, exp_rsp.read_byte,
                        rsp_status, rsp_dir_length, rsp_read_byte);
               failures++;
            end
         end
      end
   end

   // stimulus
   initial begin
      dir_row_type rows [$];
      int wait_cycles;
      rows = '{
         '{pn_pkg::FN_READ, 8'h00, 8'h00, 1, '{pn_pkg::ST_OK, 9'd1, pn_pkg::CH_SLASH}},
         '{pn_pkg::FN_READ, 8'hFF, 8'hFF, 1, '{pn_pkg::ST_OK, 9'd1, 8'h00}},
         '{pn_pkg::FN_PATH, "x",   8'hFF, 0, '0},
         '{pn_pkg::FN_PATH, "!",   8'h00, 0, '0},
         '{pn_pkg::FN_PATH, pn_pkg::CH_NUL, 8'h00, 1, '{pn_pkg::ST_BADCHAR, 9'd1, 8'h00}},
         '{pn_pkg::FN_PATH, pn_pkg::CH_NUL, 8'h00, 1, '{pn_pkg::ST_OK, 9'd1, 8'h00}},
         '{pn_pkg::FN_PATH, "a",   8'h00, 0, '0},
         '{pn_pkg::FN_PATH, pn_pkg::CH_SLASH, 8'h00, 0, '0},
         '{pn_pkg::FN_PATH, "Z",   8'h00, 0, '0},
         '{pn_pkg::FN_PATH, pn_pkg::CH_NUL, 8'h00, 0, '0},
         '{pn_pkg::FN_READ, 8'h00, 8'h03, 0, '0},
         '{pn_pkg::FN_PATH, pn_pkg::CH_DOT, 8'h00, 0, '0},
         '{pn_pkg::FN_PATH, pn_pkg::CH_SLASH, 8'h00, 0, '0},
         '{pn_pkg::FN_PATH, pn_pkg::CH_DOT, 8'h00, 0, '0},
         '{pn_pkg::FN_PATH, pn_pkg::CH_DOT, 8'h00, 0, '0},
         '{pn_pkg::FN_PATH, pn_pkg::CH_SLASH, 8'h00, 0, '0},
         '{pn_pkg::FN_PATH, pn_pkg::CH_DOT, 8'h00, 0, '0},
         '{pn_pkg::FN_PATH, pn_pkg::CH_DOT, 8'h00, 0, '0},
         '{pn_pkg::FN_PATH, pn_pkg::CH_NUL, 8'h00, 1, '{pn_pkg::ST_OK, 9'd1, 8'h00}},
         '{pn_pkg::FN_PATH, pn_pkg::CH_DOT, 8'h00, 0, '0},
         '{pn_pkg::FN_PATH, pn_pkg::CH_DOT, 8'h00, 0, '0},
         '{pn_pkg::FN_PATH, pn_pkg::CH_DOT, 8'h00, 0, '0},
         '{pn_pkg::FN_PATH, pn_pkg::CH_NUL, 8'h00, 0, '0},
         '{pn_pkg::FN_PATH, 8'hFF, 8'h00, 0, '0},
         '{pn_pkg::FN_PATH, pn_pkg::CH_NUL, 8'h00, 1, '{pn_pkg::ST_BADCHAR, 9'd4, 8'h00}}
      };
      for (int k = 0; k < DirMax; k++) begin
         cur_dir[k] = 8'h00;
         scr_dir[k] = 8'h00;
      end
      cur_dir[0] = pn_pkg::CH_SLASH;
      cur_len = 1;
      scr_len = 0;
      comp_start = 0;
      pend_dots = 0;
      in_path = 0;
      path_err = pn_pkg::ST_OK;
      reset <= 1;
      req_valid <= 0;
      req_func <= pn_pkg::FN_PATH;
      req_character <= pn_pkg::CH_NUL;
      req_index <= 8'h00;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed table
      foreach (rows[i]) send_request(rows[i].func, rows[i].ch, rows[i].idx,
                                     rows[i].typed, rows[i].rsp);

      // random paths, with a stretch of no idling in the middle
      while (sent < NumItems) begin
         quiet = (sent > 500 && sent < 700);
         random_path();
      end
      quiet = 0;
      req_valid <= 0;

      wait_cycles = 0;
      while (pending_rsp.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (failures == 0 && pending_rsp.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
